[sv/midi_voice_allocator_macros.svh]
// Assertion macros for the MIDI voice allocator.
// Expects clk_i and rst_ni in the scope of the module that uses them.
// No other dependencies.
`ifndef MIDI_VOICE_ALLOCATOR_MACROS_SVH
`define MIDI_VOICE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MVA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mva_pkg.sv]
// Shared types and constants of the MIDI voice allocator.
// Request and command structs, command codes, MIDI status and controller codes.
// No dependencies.
package mva_pkg;

  // Default voice table depth
  localparam int unsigned VOICE_COUNT_DEF = 16;
  // Commands reported per message at most
  localparam int unsigned MAX_RESULTS     = 16;
  localparam int unsigned NOTE_W          = 7;
  localparam int unsigned VALUE_W         = 28;

  // Command codes
  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_RELEASE  = 3'd2,
    CMD_NO_VOICE = 3'd3,
    CMD_FILTER   = 3'd4,
    CMD_PROGRAM  = 3'd5,
    CMD_BEND     = 3'd6
  } cmd_kind_e;

  // Status high nibbles and exact status codes
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_CONTROL  = 4'hB;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [7:0] STATUS_BEND   = 8'hE0;

  // Controller numbers
  localparam logic [6:0] CC_FILTER0 = 7'd1;
  localparam logic [6:0] CC_FILTER1 = 7'd2;
  localparam logic [6:0] CC_FILTER2 = 7'd3;
  localparam logic [6:0] CC_SUSTAIN = 7'd64;

  // Filter slots
  localparam logic [1:0] SLOT_FILTER0 = 2'd0;
  localparam logic [1:0] SLOT_FILTER1 = 2'd1;
  localparam logic [1:0] SLOT_FILTER2 = 2'd2;

  // Filter word scaling
  localparam logic [VALUE_W-1:0] FILTER0_BASE = 28'd142365917;
  localparam logic [VALUE_W-1:0] FILTER0_STEP = 28'd917175;
  localparam logic [VALUE_W-1:0] FILTER_STEP  = 28'd528416;

  localparam logic [6:0] PROGRAM_MAX = 7'd31;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
  } midi_req_t;

  typedef struct packed {
    cmd_kind_e          command_kind;
    logic [3:0]         voice_index;
    logic [6:0]         note_number;
    logic [6:0]         note_velocity;
    logic [1:0]         filter_slot;
    logic [VALUE_W-1:0] command_value;
    logic               last_of_run;
  } voice_cmd_t;

endpackage

[sv/mva_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the note of each voice in the allocator.
// No dependencies.
module mva_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/midi_voice_allocator.sv]
// Top level of the MIDI voice allocator: sequencer, voice flags, command output.
// Depends on mva_pkg, mva_ram and midi_voice_allocator_macros.svh.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o   | in_req_i  (midi_req_t)
//   out     | output    | out_valid_o / out_stall_i | out_res_o (voice_cmd_t)
//
// One message at a time. Note-off and pedal lift walk all VOICE_COUNT voices, one per
// cycle through the note RAM read port unless the output holds it up. Note-on tests one voice
// per cycle from the round-robin pointer until one is free or all were tried. Others go to S_FINISH.
// Output stalls add cycles whenever a command is ready and the output register is full.
// Reset clears flags, pointer and pedal; the note RAM needs no clearing pass.
`include "midi_voice_allocator_macros.svh"

module midi_voice_allocator #(
  parameter int unsigned VOICE_COUNT = mva_pkg::VOICE_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  mva_pkg::midi_req_t     in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output mva_pkg::voice_cmd_t    out_res_o
);

  localparam int unsigned IDX_W = $clog2(VOICE_COUNT);
  localparam int unsigned CNT_W = $clog2(VOICE_COUNT + 1);
  localparam int unsigned RES_W = $clog2(mva_pkg::MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ON,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e                      state_q, state_d;
  mva_pkg::midi_req_t          req_q, req_d;
  logic [VOICE_COUNT-1:0]      held_q, held_d;
  logic [VOICE_COUNT-1:0]      sust_q, sust_d;
  logic [IDX_W-1:0]            next_voice_q, next_voice_d;
  logic                        pedal_q, pedal_d;
  logic                        scan_off_q, scan_off_d;
  logic [CNT_W-1:0]            scan_q, scan_d;
  logic                        ev_valid_q, ev_valid_d;
  logic [IDX_W-1:0]            ev_idx_q, ev_idx_d;
  logic [IDX_W-1:0]            cand_q, cand_d;
  logic [CNT_W-1:0]            tries_q, tries_d;
  logic [RES_W-1:0]            res_cnt_q, res_cnt_d;
  logic                        pend_valid_q, pend_valid_d;
  mva_pkg::voice_cmd_t         pend_q, pend_d;
  logic                        out_valid_q, out_valid_d;
  mva_pkg::voice_cmd_t         out_q, out_d;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_raddr;
  logic [mva_pkg::NOTE_W-1:0]  ram_rdata;

  logic                        out_free;
  logic                        issue;
  logic                        hit;
  logic                        report;
  logic                        blocked;
  logic [mva_pkg::VALUE_W-1:0] filt_prod;
  mva_pkg::voice_cmd_t         cmd_new;
  logic [3:0]                  in_type;

  // Note of each voice
  mva_ram #(
    .WIDTH (mva_pkg::NOTE_W),
    .DEPTH (VOICE_COUNT)
  ) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cand_q),
    .wdata_i (req_q.data_first),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_type    = in_req_i.status_byte[7:4];

  // Shared multiplier for filter words
  assign filt_prod = mva_pkg::VALUE_W'(in_req_i.data_second) *
                     ((in_req_i.data_first == mva_pkg::CC_FILTER0) ?
                      mva_pkg::FILTER0_STEP : mva_pkg::FILTER_STEP);

  // Scan evaluation of the voice whose note is on the RAM output
  assign issue  = (scan_q < CNT_W'(VOICE_COUNT));
  assign hit    = scan_off_q ? (held_q[ev_idx_q] && (ram_rdata == req_q.data_first))
                             : (sust_q[ev_idx_q] && !held_q[ev_idx_q]);
  assign report = ev_valid_q && hit && !(scan_off_q && pedal_q) &&
                  (res_cnt_q < RES_W'(mva_pkg::MAX_RESULTS));
  assign blocked = report && pend_valid_q && !out_free;

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    held_d       = held_q;
    sust_d       = sust_q;
    next_voice_d = next_voice_q;
    pedal_d      = pedal_q;
    scan_off_d   = scan_off_q;
    scan_d       = scan_q;
    ev_valid_d   = ev_valid_q;
    ev_idx_d     = ev_idx_q;
    cand_d       = cand_q;
    tries_d      = tries_q;
    res_cnt_d    = res_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_raddr    = scan_q[IDX_W-1:0];
    cmd_new      = mva_pkg::voice_cmd_t'('0);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_req_i;
          res_cnt_d    = '0;
          pend_valid_d = 1'b0;
          ev_valid_d   = 1'b0;
          scan_d       = '0;
          state_d      = S_FINISH;
          if (in_type == mva_pkg::TYPE_NOTE_OFF ||
              (in_type == mva_pkg::TYPE_NOTE_ON && in_req_i.data_second == 7'd0)) begin
            scan_off_d = 1'b1;
            state_d    = S_SCAN;
          end else if (in_type == mva_pkg::TYPE_NOTE_ON) begin
            cand_d  = next_voice_q;
            tries_d = '0;
            state_d = S_ON;
          end else if (in_type == mva_pkg::TYPE_CONTROL) begin
            cmd_new.command_kind  = mva_pkg::CMD_FILTER;
            cmd_new.command_value = filt_prod;
            case (in_req_i.data_first)
              mva_pkg::CC_FILTER0: begin
                cmd_new.filter_slot   = mva_pkg::SLOT_FILTER0;
                cmd_new.command_value = filt_prod + mva_pkg::FILTER0_BASE;
                pend_d                = cmd_new;
                pend_valid_d          = 1'b1;
              end
              mva_pkg::CC_FILTER1: begin
                cmd_new.filter_slot = mva_pkg::SLOT_FILTER1;
                pend_d              = cmd_new;
                pend_valid_d        = 1'b1;
              end
              mva_pkg::CC_FILTER2: begin
                cmd_new.filter_slot = mva_pkg::SLOT_FILTER2;
                pend_d              = cmd_new;
                pend_valid_d        = 1'b1;
              end
              mva_pkg::CC_SUSTAIN: begin
                pedal_d = (in_req_i.data_second != 7'd0);
                if (in_req_i.data_second == 7'd0) begin
                  scan_off_d = 1'b0;
                  state_d    = S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end else if (in_type == mva_pkg::TYPE_PROGRAM) begin
            cmd_new.command_kind  = mva_pkg::CMD_PROGRAM;
            cmd_new.command_value = mva_pkg::VALUE_W'(
              (in_req_i.data_first < mva_pkg::PROGRAM_MAX) ?
              in_req_i.data_first : mva_pkg::PROGRAM_MAX);
            pend_d       = cmd_new;
            pend_valid_d = 1'b1;
          end else if (in_req_i.status_byte == mva_pkg::STATUS_BEND) begin
            cmd_new.command_kind  = mva_pkg::CMD_BEND;
            cmd_new.command_value = mva_pkg::VALUE_W'({in_req_i.data_second,
                                                      in_req_i.data_first});
            pend_d       = cmd_new;
            pend_valid_d = 1'b1;
          end
        end
      end

      // Round-robin search for a voice that is not held
      S_ON: begin
        cmd_new.note_number   = req_q.data_first;
        cmd_new.note_velocity = req_q.data_second;
        if (!held_q[cand_q]) begin
          ram_we                = 1'b1;
          held_d[cand_q]        = 1'b1;
          sust_d[cand_q]        = pedal_q;
          next_voice_d          = (cand_q == IDX_W'(VOICE_COUNT - 1)) ? '0 : cand_q + 1'b1;
          cmd_new.command_kind  = mva_pkg::CMD_START;
          cmd_new.voice_index   = 4'(cand_q);
          pend_d                = cmd_new;
          pend_valid_d          = 1'b1;
          state_d               = S_FINISH;
        end else if (tries_q == CNT_W'(VOICE_COUNT - 1)) begin
          cmd_new.command_kind = mva_pkg::CMD_NO_VOICE;
          pend_d               = cmd_new;
          pend_valid_d         = 1'b1;
          state_d              = S_FINISH;
        end else begin
          cand_d  = (cand_q == IDX_W'(VOICE_COUNT - 1)) ? '0 : cand_q + 1'b1;
          tries_d = tries_q + 1'b1;
        end
      end

      // Walk all voices: note-off match or pedal-lift release
      S_SCAN: begin
        if (blocked) begin
          ram_raddr = ev_idx_q;
        end else begin
          if (issue) begin
            ev_idx_d = scan_q[IDX_W-1:0];
            scan_d   = scan_q + 1'b1;
          end
          ev_valid_d = issue;
          if (ev_valid_q && hit) begin
            if (scan_off_q) begin
              held_d[ev_idx_q] = 1'b0;
              if (pedal_q) begin
                sust_d[ev_idx_q] = 1'b1;
              end
            end else begin
              sust_d[ev_idx_q] = 1'b0;
            end
          end
          if (report) begin
            if (pend_valid_q) begin
              out_d       = pend_q;
              out_valid_d = 1'b1;
            end
            cmd_new.command_kind = mva_pkg::CMD_RELEASE;
            cmd_new.voice_index  = 4'(ev_idx_q);
            pend_d               = cmd_new;
            pend_valid_d         = 1'b1;
            res_cnt_d            = res_cnt_q + 1'b1;
          end
          if (!issue && !ev_valid_q) begin
            state_d = S_FINISH;
          end
        end
      end

      // Deliver the held-back command, or a null one, as last of the run
      S_FINISH: begin
        if (out_free) begin
          out_d             = pend_valid_q ? pend_q : mva_pkg::voice_cmd_t'('0);
          out_d.last_of_run = 1'b1;
          out_valid_d       = 1'b1;
          pend_valid_d      = 1'b0;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= '0;
      held_q       <= '0;
      sust_q       <= '0;
      next_voice_q <= '0;
      pedal_q      <= 1'b0;
      scan_off_q   <= 1'b0;
      scan_q       <= '0;
      ev_valid_q   <= 1'b0;
      ev_idx_q     <= '0;
      cand_q       <= '0;
      tries_q      <= '0;
      res_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      req_q        <= req_d;
      held_q       <= held_d;
      sust_q       <= sust_d;
      next_voice_q <= next_voice_d;
      pedal_q      <= pedal_d;
      scan_off_q   <= scan_off_d;
      scan_q       <= scan_d;
      ev_valid_q   <= ev_valid_d;
      ev_idx_q     <= ev_idx_d;
      cand_q       <= cand_d;
      tries_q      <= tries_d;
      res_cnt_q    <= res_cnt_d;
      pend_valid_q <= pend_valid_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // A new request starts with nothing left over from the previous one
  `MVA_ASSERT_SAME(a_accept_clean, in_valid_i && !in_stall_o, !pend_valid_q && !ev_valid_q, "request accepted with command or scan pending")
  // Round-robin pointer stays inside the voice table
  `MVA_ASSERT_SAME(a_ptr_range, 1'b1, CNT_W'(next_voice_q) < CNT_W'(VOICE_COUNT), "voice pointer out of range")
  // A free voice found by the search is taken at once
  `MVA_ASSERT_NEXT(a_start_holds, state_q == S_ON && !held_q[cand_q], held_q[$past(cand_q)] && state_q == S_FINISH, "free voice not claimed")
  // Closing a run always leaves a last command on the output
  `MVA_ASSERT_NEXT(a_finish_last, state_q == S_FINISH && (!out_valid_q || !out_stall_i), state_q == S_IDLE && out_valid_q && out_q.last_of_run, "run closed without last command")

endmodule

[verif/midi_voice_allocator_tb.sv]
// Self-checking testbench for midi_voice_allocator: directed and random MIDI requests.
// A scoreboard class tracks the voice table and checks every command in order.
// Depends on mva_pkg and the midi_voice_allocator RTL.
module midi_voice_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mva_pkg::*;

  localparam int unsigned VOICES       = VOICE_COUNT_DEF;
  localparam int unsigned ITEMS        = 310;
  localparam int unsigned HOLD_AFTER   = 60;   // commands seen before the long sink hold-off
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 3 * (VOICES + 3);

  // Voice table tracker and in-order command checker
  class voice_cmd_checker;
    logic [6:0]  note_of[VOICES];
    bit          key_down[VOICES];
    bit          sustain_flag[VOICES];
    int unsigned rr_next;
    bit          pedal_is_down;
    voice_cmd_t  run_cmds[$];
    voice_cmd_t  expected_cmds[$];
    int unsigned mismatches;
    int unsigned commands_checked;

    function new();
      foreach (note_of[i]) begin
        note_of[i]      = '0;
        key_down[i]     = 1'b0;
        sustain_flag[i] = 1'b0;
      end
      rr_next          = 0;
      pedal_is_down    = 1'b0;
      mismatches       = 0;
      commands_checked = 0;
    endfunction

    function voice_cmd_t make_cmd(cmd_kind_e kind);
      voice_cmd_t c;
      c = '0;
      c.command_kind = kind;
      return c;
    endfunction

    // Commands past the per-message limit are dropped, the voices still update
    function void stage(voice_cmd_t c);
      if (run_cmds.size() < MAX_RESULTS) run_cmds.push_back(c);
    endfunction

    // Update the voice table for one accepted request and queue its commands
    function void note_message(midi_req_t m);
      voice_cmd_t  c;
      logic [3:0]  kind_nib;
      int unsigned cand;
      int unsigned v;
      bit          found;
      kind_nib = m.status_byte[7:4];
      run_cmds.delete();
      if (kind_nib == TYPE_NOTE_OFF || (kind_nib == TYPE_NOTE_ON && m.data_second == 0)) begin
        for (v = 0; v < VOICES; v++) begin
          if (key_down[v] && note_of[v] == m.data_first) begin
            if (pedal_is_down) begin
              sustain_flag[v] = 1'b1;
            end else begin
              c = make_cmd(CMD_RELEASE);
              c.voice_index = 4'(v);
              stage(c);
            end
            key_down[v] = 1'b0;
          end
        end
      end else if (kind_nib == TYPE_NOTE_ON) begin
        // round-robin search for a free key
        cand  = rr_next % VOICES;
        found = 1'b0;
        for (v = 0; v < VOICES && !found; v++) begin
          if (!key_down[cand]) found = 1'b1;
          else cand = (cand + 1) % VOICES;
        end
        if (found) begin
          rr_next            = (cand + 1) % VOICES;
          note_of[cand]      = m.data_first;
          key_down[cand]     = 1'b1;
          sustain_flag[cand] = pedal_is_down;
          c = make_cmd(CMD_START);
          c.voice_index = 4'(cand);
        end else begin
          c = make_cmd(CMD_NO_VOICE);
        end
        c.note_number   = m.data_first;
        c.note_velocity = m.data_second;
        stage(c);
      end else if (kind_nib == TYPE_CONTROL) begin
        c = make_cmd(CMD_FILTER);
        if (m.data_first == CC_FILTER0) begin
          c.filter_slot   = SLOT_FILTER0;
          c.command_value = FILTER0_BASE + VALUE_W'(m.data_second) * FILTER0_STEP;
          stage(c);
        end else if (m.data_first == CC_FILTER1) begin
          c.filter_slot   = SLOT_FILTER1;
          c.command_value = VALUE_W'(m.data_second) * FILTER_STEP;
          stage(c);
        end else if (m.data_first == CC_FILTER2) begin
          c.filter_slot   = SLOT_FILTER2;
          c.command_value = VALUE_W'(m.data_second) * FILTER_STEP;
          stage(c);
        end else if (m.data_first == CC_SUSTAIN) begin
          pedal_is_down = (m.data_second != 0);
          // pedal lift frees every sustained voice whose key is up
          if (!pedal_is_down) begin
            for (v = 0; v < VOICES; v++) begin
              if (sustain_flag[v] && !key_down[v]) begin
                c = make_cmd(CMD_RELEASE);
                c.voice_index = 4'(v);
                stage(c);
                sustain_flag[v] = 1'b0;
              end
            end
          end
        end
      end else if (kind_nib == TYPE_PROGRAM) begin
        c = make_cmd(CMD_PROGRAM);
        c.command_value = VALUE_W'((m.data_first < PROGRAM_MAX) ? m.data_first : PROGRAM_MAX);
        stage(c);
      end else if (m.status_byte == STATUS_BEND) begin
        c = make_cmd(CMD_BEND);
        c.command_value = VALUE_W'({m.data_second, m.data_first});
        stage(c);
      end
      if (run_cmds.size() == 0) stage(make_cmd(CMD_NONE));
      run_cmds[run_cmds.size() - 1].last_of_run = 1'b1;
      foreach (run_cmds[i]) expected_cmds.push_back(run_cmds[i]);
    endfunction

    function void compare_field(string what, logic [27:0] want, logic [27:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted command with the oldest queued expectation
    function void check_command(voice_cmd_t got);
      voice_cmd_t want;
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected command, expected none, actual kind %0d",
                 $time, got.command_kind);
        mismatches++;
        return;
      end
      want = expected_cmds.pop_front();
      commands_checked++;
      compare_field("command_kind", want.command_kind, got.command_kind);
      compare_field("voice_index", want.voice_index, got.voice_index);
      compare_field("note_number", want.note_number, got.note_number);
      compare_field("note_velocity", want.note_velocity, got.note_velocity);
      compare_field("filter_slot", want.filter_slot, got.filter_slot);
      compare_field("command_value", want.command_value, got.command_value);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function int unsigned commands_waiting();
      return expected_cmds.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  midi_req_t  in_req_i    = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  voice_cmd_t out_res_o;

  voice_cmd_checker board = new();
  int unsigned      items_sent = 0;
  bit               tx_quiet   = 1'b0;

  midi_voice_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #15ms;
    $display("FAIL midi_voice_allocator");
    $finish;
  end

  // Offer one request, hold it until accepted, then idle a random gap
  task automatic send_request(logic [7:0] status, logic [6:0] d1, logic [6:0] d2);
    midi_req_t   m;
    int unsigned gap;
    int unsigned r;
    m.status_byte = status;
    m.data_first  = d1;
    m.data_second = d2;
    in_valid_i <= 1'b1;
    in_req_i   <= m;
    do @(posedge clk_i); while (in_stall_o);
    board.note_message(m);
    if (status[7:4] inside {TYPE_NOTE_OFF, TYPE_NOTE_ON, TYPE_CONTROL, TYPE_PROGRAM} ||
        status == STATUS_BEND) items_sent++;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = 0;
    if (!tx_quiet) begin
      r = $urandom_range(0, 99);
      if (r >= 55) gap = (r < 90) ? $urandom_range(1, 3) : $urandom_range(6, 30);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [3:0] any_channel();
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic press_key(logic [6:0] note);
    send_request({TYPE_NOTE_ON, any_channel()}, note, 7'($urandom_range(1, 127)));
  endtask

  // Note-off either as its own status or as a zero-velocity note-on
  task automatic release_key(logic [6:0] note);
    if ($urandom_range(0, 1) != 0)
      send_request({TYPE_NOTE_OFF, any_channel()}, note, 7'($urandom_range(0, 127)));
    else
      send_request({TYPE_NOTE_ON, any_channel()}, note, 7'd0);
  endtask

  task automatic set_pedal(bit down);
    send_request({TYPE_CONTROL, any_channel()}, CC_SUSTAIN,
                 down ? 7'($urandom_range(1, 127)) : 7'd0);
  endtask

  // A few keys pressed and released in random order, optionally under the pedal
  task automatic play_phrase(bit with_pedal);
    logic [6:0]  keys[$];
    logic [6:0]  note;
    int unsigned count;
    int unsigned idx;
    count = $urandom_range(1, 6);
    if (with_pedal) set_pedal(1'b1);
    repeat (count) begin
      if (keys.size() != 0 && $urandom_range(0, 3) == 0)
        note = keys[$urandom_range(0, keys.size() - 1)];
      else
        note = 7'($urandom_range(0, 127));
      press_key(note);
      keys.push_back(note);
      if ($urandom_range(0, 2) == 0) begin
        idx = $urandom_range(0, keys.size() - 1);
        release_key(keys[idx]);
        keys.delete(idx);
      end
    end
    while (keys.size() != 0) begin
      idx = $urandom_range(0, keys.size() - 1);
      release_key(keys[idx]);
      keys.delete(idx);
    end
    if (with_pedal && $urandom_range(0, 3) != 0) set_pedal(1'b0);
  endtask

  // Many keys on few notes: fills the table, multi-voice releases, big pedal lifts
  task automatic fill_voices();
    logic [6:0]  pool[3];
    int unsigned count;
    foreach (pool[i]) pool[i] = 7'($urandom_range(0, 127));
    count = $urandom_range(10, 20);
    if ($urandom_range(0, 1) != 0) set_pedal(1'b1);
    repeat (count) press_key(pool[$urandom_range(0, 2)]);
    foreach (pool[i]) release_key(pool[i]);
    set_pedal(1'b0);
  endtask

  task automatic send_controls();
    logic [6:0]  num;
    int unsigned r;
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(0, 4);
      case (r)
        0: num = CC_FILTER0;
        1: num = CC_FILTER1;
        2: num = CC_FILTER2;
        3: num = CC_SUSTAIN;
        default: num = 7'($urandom_range(0, 127));
      endcase
      if (num == CC_SUSTAIN && $urandom_range(0, 1) != 0)
        send_request({TYPE_CONTROL, any_channel()}, num, 7'd0);
      else
        send_request({TYPE_CONTROL, any_channel()}, num, 7'($urandom_range(0, 127)));
    end
  endtask

  // Program change or pitch bend; bend on a channel other than 0 is ignored
  task automatic send_program_or_bend();
    if ($urandom_range(0, 1) != 0)
      send_request({TYPE_PROGRAM, any_channel()}, 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)));
    else if ($urandom_range(0, 4) != 0)
      send_request(STATUS_BEND, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    else
      send_request(STATUS_BEND | {4'd0, any_channel()}, 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)));
  endtask

  // Command sink: checks accepted commands and stalls at random
  initial begin : command_sink
    int unsigned stall_left;
    int unsigned r;
    bit          held_off;
    bit          rx_quiet;
    stall_left = 0;
    held_off   = 1'b0;
    rx_quiet   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) board.check_command(out_res_o);
      if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
      if (!held_off && board.commands_checked >= HOLD_AFTER) begin
        // long hold-off so the block backs up into its input
        held_off   = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !rx_quiet) begin
        r = $urandom_range(0, 99);
        if (r >= 60) stall_left = (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Request source and end of run
  initial begin : request_source
    int unsigned r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // note-on at the extremes, channel ignored
    send_request({TYPE_NOTE_ON, 4'h0}, 7'd60, 7'd127);
    send_request({TYPE_NOTE_ON, 4'hF}, 7'd0, 7'd1);
    send_request({TYPE_NOTE_ON, 4'h0}, 7'd127, 7'd64);
    // note-off, zero-velocity note-on, note-off matching nothing
    send_request({TYPE_NOTE_OFF, 4'h0}, 7'd60, 7'd0);
    send_request({TYPE_NOTE_ON, 4'h5}, 7'd0, 7'd0);
    send_request({TYPE_NOTE_OFF, 4'hA}, 7'd99, 7'd127);
    // filter controllers
    send_request({TYPE_CONTROL, 4'h0}, CC_FILTER0, 7'd0);
    send_request({TYPE_CONTROL, 4'hF}, CC_FILTER0, 7'd127);
    send_request({TYPE_CONTROL, 4'h0}, CC_FILTER1, 7'd127);
    send_request({TYPE_CONTROL, 4'h0}, CC_FILTER2, 7'd1);
    // note-off under the pedal, then a key pressed while the pedal is down
    send_request({TYPE_CONTROL, 4'h0}, CC_SUSTAIN, 7'd127);
    send_request({TYPE_NOTE_OFF, 4'h0}, 7'd127, 7'd0);
    send_request({TYPE_NOTE_ON, 4'h0}, 7'd70, 7'd5);
    // lift releases the sustained voice only; the held one keeps its flag
    send_request({TYPE_CONTROL, 4'h0}, CC_SUSTAIN, 7'd0);
    send_request({TYPE_NOTE_OFF, 4'h0}, 7'd70, 7'd0);
    // a second lift releases the already silent voice again
    send_request({TYPE_CONTROL, 4'h0}, CC_SUSTAIN, 7'd1);
    send_request({TYPE_CONTROL, 4'h0}, CC_SUSTAIN, 7'd0);
    // other controller, program clamp, bend, ignored statuses
    send_request({TYPE_CONTROL, 4'h0}, 7'd7, 7'd100);
    send_request({TYPE_PROGRAM, 4'h0}, 7'd0, 7'd0);
    send_request({TYPE_PROGRAM, 4'h5}, 7'd127, 7'd0);
    send_request(STATUS_BEND, 7'd0, 7'd0);
    send_request(STATUS_BEND, 7'd127, 7'd127);
    send_request(STATUS_BEND | 8'h01, 7'd5, 7'd5);
    send_request(8'hF0, 7'd0, 7'd0);
    send_request(8'h00, 7'd127, 7'd127);

    // random traffic, mostly well-formed phrases
    while (items_sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 30) play_phrase(1'b0);
      else if (r < 45) play_phrase(1'b1);
      else if (r < 57) fill_voices();
      else if (r < 72) send_controls();
      else if (r < 85) send_program_or_bend();
      else
        repeat ($urandom_range(1, 3))
          send_request(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 127)));
    end
    in_valid_i <= 1'b0;

    while (board.commands_waiting() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("PASS midi_voice_allocator");
    end else begin
      $display("FAIL midi_voice_allocator");
    end
    $finish;
  end

endmodule
